FILE: sv/ncv_pkg.sv
// Shared widths and ring control type for the normalized convolution block.
package ncv_pkg;

  localparam int HIST_W = 32;
  localparam int KERN_W = 16;
  localparam int TOT_W  = 22;
  localparam int Q_W    = 32;
  localparam int PROD_W = HIST_W + KERN_W;

  typedef struct packed {
    logic h_fwd;
    logic g_fwd;
    logic g_bwd;
  } ncv_ring_t;

endpackage

FILE: sv/ncv_cell.sv
// One ring cell: holds a histogram bin and a kernel bin, shifts with its neighbours.
module ncv_cell import ncv_pkg::*; (
  input  logic              clk,
  input  ncv_ring_t         ring,
  input  logic              ld,
  input  logic [HIST_W-1:0] ld_h,
  input  logic [KERN_W-1:0] ld_g,
  input  logic [HIST_W-1:0] h_right,
  input  logic [KERN_W-1:0] g_right,
  input  logic [KERN_W-1:0] g_left,
  output logic [HIST_W-1:0] h_q,
  output logic [KERN_W-1:0] g_q
);

  logic [HIST_W-1:0] h_r;
  logic [KERN_W-1:0] g_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      h_r <= ld_h;
      g_r <= ld_g;
    end else begin
      if (ring.h_fwd) begin
        h_r <= h_right;
      end
      if (ring.g_fwd) begin
        g_r <= g_right;
      end else if (ring.g_bwd) begin
        g_r <= g_left;
      end
    end
  end

  assign h_q = h_r;
  assign g_q = g_r;

endmodule

FILE: sv/ncv_div.sv
// Restoring divider, one quotient bit per cycle.
module ncv_div import ncv_pkg::*; #(
  parameter int DW = 54
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [TOT_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [TOT_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [TOT_W:0]   shifted;
  logic [TOT_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted  = {rem_r, q_r[DW-1]};
    diff     = shifted - {1'b0, divisor};
    ge       = (shifted >= {1'b0, divisor});
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      q_nxt   = dividend;
      cnt_nxt = CNT_W'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[TOT_W-1:0] : shifted[TOT_W-1:0];
      q_nxt   = {q_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[Q_W-1:0];

endmodule

FILE: sv/normalized_same_convolution.sv
// Top level: ring of bin cells, shared multiply-accumulate and divider.
//
//   channel  ports                                   handshake
//   input    in_hist_value, in_kernel_value,
//            in_last_pair                            start & !busy
//   result   out_smeared_value, out_last_result,
//            out_zero_kernel                         out_strobe, one cycle
//
// A pair without the last mark leaves the block idle for the next pair. After the
// last pair, the kernel ring is turned to the centre offset; each result then steps
// all NBINS_MAX cells past the single multiplier, flushes the product, starts the
// divider and waits for its quotient; the kernel ring is turned home afterwards.
// Reset empties the frame; the stores need no clearing. Results cannot be stalled.
module normalized_same_convolution import ncv_pkg::*; #(
  parameter int NBINS_MAX = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [HIST_W-1:0] in_hist_value,
  input  logic [KERN_W-1:0] in_kernel_value,
  input  logic              in_last_pair,
  output logic              out_strobe,
  output logic [Q_W-1:0]    out_smeared_value,
  output logic              out_last_result,
  output logic              out_zero_kernel
);

  localparam int KW    = (NBINS_MAX > 1) ? $clog2(NBINS_MAX) : 1;
  localparam int CW    = $clog2(NBINS_MAX + 1);
  localparam int JW    = $clog2(2 * NBINS_MAX);
  localparam int ACC_W = PROD_W + $clog2(NBINS_MAX);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_COMP = 7'b0000100,
    S_FLSH = 7'b0001000,
    S_DST  = 7'b0010000,
    S_DWT  = 7'b0100000,
    S_UNW  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [KW-1:0]     off_r, off_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [KW-1:0]     t_r, t_nxt;
  logic [KW-1:0]     i_r, i_nxt;
  logic [KW-1:0]     g_rot_r, g_rot_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic [Q_W-1:0]    out_val_r, out_val_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_zk_r, out_zk_nxt;
  logic              div_start;
  logic              div_done;
  logic [Q_W-1:0]    div_q;

  logic              accept;
  logic              store_ok;
  logic [CW-1:0]     n_new;
  logic [CW-1:0]     off_new;
  logic              tap_ok;
  logic [JW-1:0]     t_ext;
  logic [JW-1:0]     n_ext;
  logic [JW-1:0]     jt_diff;
  logic              last_out;
  ncv_ring_t         ring;

  logic [HIST_W-1:0] h_q [NBINS_MAX];
  logic [KERN_W-1:0] g_q [NBINS_MAX];

  assign accept   = start && (state_r == S_IDLE);
  assign store_ok = (cnt_r < CW'(NBINS_MAX));
  assign busy     = (state_r != S_IDLE);

  for (genvar c = 0; c < NBINS_MAX; c++) begin : g_ring
    localparam int R = (c + 1) % NBINS_MAX;
    localparam int L = (c + NBINS_MAX - 1) % NBINS_MAX;
    ncv_cell u_cell (
      .clk     (clk),
      .ring    (ring),
      .ld      (accept && store_ok && (cnt_r == CW'(c))),
      .ld_h    (in_hist_value),
      .ld_g    (in_kernel_value),
      .h_right (h_q[R]),
      .g_right (g_q[R]),
      .g_left  (g_q[L]),
      .h_q     (h_q[c]),
      .g_q     (g_q[c])
    );
  end

  ncv_div #(.DW(ACC_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (tot_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    n_new    = store_ok ? cnt_r + CW'(1) : cnt_r;
    off_new  = n_new[0] ? (n_new >> 1) : (n_new >> 1) - CW'(1);
    t_ext    = JW'(t_r);
    n_ext    = JW'(n_r);
    jt_diff  = j_r - t_ext;
    tap_ok   = (CW'(t_r) < n_r) && (j_r >= t_ext) && (jt_diff < n_ext);
    last_out = (CW'(i_r) == n_r - CW'(1));
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    tot_nxt        = tot_r;
    n_nxt          = n_r;
    off_nxt        = off_r;
    j_nxt          = j_r;
    t_nxt          = t_r;
    i_nxt          = i_r;
    g_rot_nxt      = g_rot_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    out_strobe_nxt = 1'b0;
    out_val_nxt    = out_val_r;
    out_last_nxt   = out_last_r;
    out_zk_nxt     = out_zk_r;
    div_start      = 1'b0;
    ring           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (store_ok) begin
            cnt_nxt = cnt_r + CW'(1);
            tot_nxt = tot_r + TOT_W'(in_kernel_value);
          end
          if (in_last_pair) begin
            n_nxt     = n_new;
            off_nxt   = KW'(off_new);
            j_nxt     = JW'(off_new);
            i_nxt     = '0;
            t_nxt     = '0;
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        if (g_rot_r == off_r) begin
          state_nxt = S_COMP;
        end else begin
          ring.g_fwd = 1'b1;
          g_rot_nxt  = (g_rot_r == KW'(NBINS_MAX - 1)) ? '0 : g_rot_r + KW'(1);
        end
      end
      S_COMP: begin
        ring.h_fwd = 1'b1;
        ring.g_bwd = 1'b1;
        prod_nxt   = tap_ok ? PROD_W'(h_q[0]) * PROD_W'(g_q[0]) : '0;
        acc_nxt    = (t_r == '0) ? '0 : acc_r + ACC_W'(prod_r);
        if (t_r == KW'(NBINS_MAX - 1)) begin
          t_nxt     = '0;
          state_nxt = S_FLSH;
        end else begin
          t_nxt = t_r + KW'(1);
        end
      end
      S_FLSH: begin
        acc_nxt    = acc_r + ACC_W'(prod_r);
        ring.g_fwd = 1'b1;
        g_rot_nxt  = (g_rot_r == KW'(NBINS_MAX - 1)) ? '0 : g_rot_r + KW'(1);
        state_nxt  = S_DST;
      end
      S_DST: begin
        div_start = 1'b1;
        state_nxt = S_DWT;
      end
      S_DWT: begin
        if (div_done) begin
          out_strobe_nxt = 1'b1;
          out_zk_nxt     = (tot_r == '0);
          out_val_nxt    = (tot_r == '0) ? '0 : div_q;
          out_last_nxt   = last_out;
          if (last_out) begin
            state_nxt = S_UNW;
          end else begin
            i_nxt     = i_r + KW'(1);
            j_nxt     = j_r + JW'(1);
            t_nxt     = '0;
            state_nxt = S_COMP;
          end
        end
      end
      S_UNW: begin
        if (g_rot_r == '0) begin
          cnt_nxt   = '0;
          tot_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ring.g_bwd = 1'b1;
          g_rot_nxt  = g_rot_r - KW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      tot_r        <= '0;
      g_rot_r      <= '0;
      out_strobe_r <= 1'b0;
      t_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      n_r          <= '0;
      off_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      tot_r        <= tot_nxt;
      g_rot_r      <= g_rot_nxt;
      out_strobe_r <= out_strobe_nxt;
      t_r          <= t_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      n_r          <= n_nxt;
      off_r        <= off_nxt;
    end
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_zk_r   <= out_zk_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_smeared_value = out_val_r;
  assign out_last_result   = out_last_r;
  assign out_zero_kernel   = out_zk_r;

`ifndef NO_ASSERTIONS
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == S_COMP || state_r == S_UNW))
    else $error("result word outside a frame");
  a_idle_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (g_rot_r == '0))
    else $error("kernel ring not home while idle");
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_zk_r) |-> (out_val_r == '0))
    else $error("zero kernel word with nonzero value");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWT))
    else $error("divider finished outside wait");
`endif

endmodule
